FILE: design/dctcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCTCP alpha estimator package
// Shared constants, control types and the microcode ROM of the sequencer.
// ----------------------------------------------------------------------------
package dctcp_pkg;

  // Default datapath sizing
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Configuration port
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 17;
  localparam logic [CFG_IW-1:0] REG_SEG_SIZE = 1'b0;
  localparam logic [CFG_IW-1:0] REG_GAIN     = 1'b1;
  localparam logic [15:0]       SEG_SIZE_RST = 16'd1448;
  localparam logic [CFG_DW-1:0] GAIN_RST     = 17'd4096;

  // Input stream layout: segs_acked, ece_seen, tx_mark, ack_seq, cur_window, in_flight
  localparam int IN_DW = 152;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_BYTES,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_DECAY,
    OP_MUL_GAIN,
    OP_ALPHA,
    OP_MUL_REDUCE,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_QUERY,
    C_NO_WINDOW,
    C_DIV_SKIP,
    C_DIV_MORE
  } cond_t;

  localparam int UPC_W = 4;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Program addresses
  localparam logic [UPC_W-1:0] U_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] U_MUL_B    = 4'd1;
  localparam logic [UPC_W-1:0] U_ACCUM    = 4'd2;
  localparam logic [UPC_W-1:0] U_DIV_INIT = 4'd3;
  localparam logic [UPC_W-1:0] U_DIV_STEP = 4'd4;
  localparam logic [UPC_W-1:0] U_DECAY    = 4'd5;
  localparam logic [UPC_W-1:0] U_GAIN     = 4'd6;
  localparam logic [UPC_W-1:0] U_ALPHA    = 4'd7;
  localparam logic [UPC_W-1:0] U_EMIT_ACK = 4'd8;
  localparam logic [UPC_W-1:0] U_QUERY    = 4'd9;
  localparam logic [UPC_W-1:0] U_EMIT_Q   = 4'd10;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic query;
    logic no_window;
    logic div_skip;
    logic div_more;
  } stat_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t  op;
    logic fire;
  } ctl_t;

  // Microcode ROM
  function automatic uword_t ucode(logic [UPC_W-1:0] pc);
    uword_t w;
    case (pc)
      U_IDLE:     w = '{OP_LOAD,       C_NEXT,      U_IDLE};
      U_MUL_B:    w = '{OP_MUL_BYTES,  C_QUERY,     U_QUERY};
      U_ACCUM:    w = '{OP_ACCUM,      C_NO_WINDOW, U_EMIT_ACK};
      U_DIV_INIT: w = '{OP_DIV_INIT,   C_DIV_SKIP,  U_DECAY};
      U_DIV_STEP: w = '{OP_DIV_STEP,   C_DIV_MORE,  U_DIV_STEP};
      U_DECAY:    w = '{OP_MUL_DECAY,  C_NEXT,      U_IDLE};
      U_GAIN:     w = '{OP_MUL_GAIN,   C_NEXT,      U_IDLE};
      U_ALPHA:    w = '{OP_ALPHA,      C_NEXT,      U_IDLE};
      U_EMIT_ACK: w = '{OP_EMIT,       C_ALWAYS,    U_IDLE};
      U_QUERY:    w = '{OP_MUL_REDUCE, C_NEXT,      U_IDLE};
      U_EMIT_Q:   w = '{OP_EMIT,       C_ALWAYS,    U_IDLE};
      default:    w = '{OP_NOP,        C_ALWAYS,    U_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/dctcp_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCTCP microcode sequencer
// Step counter over the microcode ROM; holds on input or output stalls and
// takes conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module dctcp_useq (
  input  logic            clk,
  input  logic            rst,
  input  dctcp_pkg::stat_t stat,
  output dctcp_pkg::ctl_t  ctl
);
  import dctcp_pkg::*;

  logic [UPC_W-1:0] pc;
  logic [UPC_W-1:0] pc_next;
  uword_t           uw;
  logic             cond_hit;
  logic             stall;

  // Fetch the control word
  always_comb begin
    uw = ucode(pc);
  end

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      C_NEXT:      cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_QUERY:     cond_hit = stat.query;
      C_NO_WINDOW: cond_hit = stat.no_window;
      C_DIV_SKIP:  cond_hit = stat.div_skip;
      C_DIV_MORE:  cond_hit = stat.div_more;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Hold while waiting for a request or for room in the output register
  always_comb begin
    stall = ((uw.op == OP_LOAD) && !stat.in_valid) ||
            ((uw.op == OP_EMIT) && stat.out_busy);
  end

  // Next step
  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + UPC_W'(1);
    end
  end

  // Drive the datapath
  always_comb begin
    ctl.op   = uw.op;
    ctl.fire = !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= U_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: design/dctcp_alpha_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCTCP alpha estimator
// Accumulates acked and ECN-marked bytes, updates alpha at each window end
// and answers window reduction queries, under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Accept to result: an ack closing a window runs the restoring divider, one
// quotient bit per microcode step, then the alpha blend; the division is
// skipped when nothing was acked or every byte was marked. A new request is
// taken only after the last one has been emitted; the result register frees
// the input side while a result waits. Reset (rst, synchronous) sets alpha
// to 1.0, clears counters and mark, loads defaults.
// ----------------------------------------------------------------------------
module dctcp_alpha_estimator_top #(
  parameter int FRAC_BITS   = dctcp_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = dctcp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dctcp_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [dctcp_pkg::CFG_DW-1:0]           cfg_data,
  // Requests
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // segs_acked, ece_seen, tx_mark, ack_seq, cur_window, in_flight, zero pad
  input  logic [dctcp_pkg::IN_DW-1:0]            s_axis_tdata,
  // func
  input  logic                                   s_axis_tuser,
  // Results
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // alpha_now, reduced_window, slow_start_thresh, zero pad
  output logic [((FRAC_BITS+1+64+7)/8)*8-1:0]    m_axis_tdata,
  // alpha_updated
  output logic                                   m_axis_tuser
);
  import dctcp_pkg::*;

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int MB    = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
  localparam int PW    = 32 + MB;
  localparam int AW2   = 2 * FRAC_BITS + 2;
  localparam int SW    = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam int ODW   = ((ONE_W + 64 + 7) / 8) * 8;
  localparam int GW    = (ONE_W > CFG_DW) ? ONE_W : CFG_DW;
  localparam logic [ONE_W-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ONE_W:0]     TWO_ONE = {2'b10, {FRAC_BITS{1'b0}}};

  // Sequencer link
  stat_t stat;
  ctl_t  ctl;

  // Configuration
  logic [15:0]       seg_size;
  logic [CFG_DW-1:0] gain;

  // Estimator state
  logic [ONE_W-1:0]       alpha;
  logic [COUNT_WIDTH-1:0] acked;
  logic [COUNT_WIDTH-1:0] marked;
  logic [31:0]            mark;

  // Captured request
  logic        func;
  logic [15:0] segs;
  logic        ece;
  logic [31:0] txm;
  logic [31:0] ackn;
  logic [31:0] cwnd;
  logic [31:0] infl;

  // Working registers
  logic [PW-1:0]          prod;
  logic [AW2-1:0]         acc;
  logic [COUNT_WIDTH-1:0] r;
  logic [ONE_W-1:0]       q;
  logic [CNT_W-1:0]       cnt;
  logic                   updated;

  // Result register
  logic             out_valid;
  logic [ONE_W-1:0] out_alpha;
  logic             out_upd;
  logic [31:0]      out_red;
  logic [31:0]      out_sst;

  // Datapath signals
  logic                   in_accept;
  logic [GW-1:0]          gain_ext;
  logic [ONE_W-1:0]       g;
  logic [31:0]            mul_a;
  logic [MB-1:0]          mul_b;
  logic [31:0]            bytes;
  logic [SW-1:0]          acked_sum;
  logic [SW-1:0]          marked_sum;
  logic [31:0]            win_diff;
  logic [COUNT_WIDTH:0]   rs;
  logic [COUNT_WIDTH:0]   rdiff;
  logic                   ge;
  logic [AW2:0]           asum;
  logic [FRAC_BITS+2:0]   ashr;
  logic [ONE_W-1:0]       alpha_new;
  logic [31:0]            reduced;
  logic [31:0]            half;

  dctcp_useq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Handshakes
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (ctl.op == OP_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = ODW'({out_sst, out_red, out_alpha});
  assign m_axis_tuser  = out_upd;

  // Clip gain at one
  always_comb begin
    gain_ext = GW'(gain);
    g        = (gain_ext > GW'(ONE)) ? ONE : gain_ext[ONE_W-1:0];
  end

  // Select multiplier operands
  always_comb begin
    case (ctl.op)
      OP_MUL_BYTES: begin
        mul_a = 32'(segs);
        mul_b = MB'(seg_size);
      end
      OP_MUL_DECAY: begin
        mul_a = 32'(ONE - g);
        mul_b = MB'(alpha);
      end
      OP_MUL_GAIN: begin
        mul_a = 32'(g);
        mul_b = MB'(q);
      end
      OP_MUL_REDUCE: begin
        mul_a = cwnd;
        mul_b = MB'(TWO_ONE - {1'b0, alpha});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating counter sums, window test, divider step, alpha blend, reduced window
  always_comb begin
    bytes      = prod[31:0];
    acked_sum  = SW'(acked) + SW'(bytes);
    marked_sum = SW'(marked) + SW'(bytes);
    win_diff   = ackn - mark;
    rs         = {r, 1'b0};
    rdiff      = rs - {1'b0, acked};
    ge         = (rs >= {1'b0, acked});
    asum       = (AW2+1)'(acc) + (AW2+1)'(prod[AW2-1:0]);
    ashr       = asum[AW2:FRAC_BITS];
    alpha_new  = (ashr > (FRAC_BITS+3)'(ONE)) ? ONE : ashr[ONE_W-1:0];
    reduced    = prod[FRAC_BITS+1 +: 32];
    half       = infl >> 1;
  end

  // Status to the sequencer
  always_comb begin
    stat.in_valid  = s_axis_tvalid;
    stat.out_busy  = out_valid && !m_axis_tready;
    stat.query     = func;
    stat.no_window = win_diff[31];
    stat.div_skip  = (acked == '0) || (marked >= acked);
    stat.div_more  = (cnt != CNT_W'(FRAC_BITS - 1));
  end

  // Apply configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size <= SEG_SIZE_RST;
      gain     <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEG_SIZE: seg_size <= cfg_data[15:0];
        REG_GAIN:     gain     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= ONE;
      acked  <= '0;
      marked <= '0;
      mark   <= '0;
    end else if (ctl.fire) begin
      case (ctl.op)
        OP_ACCUM: begin
          acked <= (|acked_sum[SW-1:COUNT_WIDTH]) ? '1 : acked_sum[COUNT_WIDTH-1:0];
          if (ece) begin
            marked <= (|marked_sum[SW-1:COUNT_WIDTH]) ? '1 :
                      marked_sum[COUNT_WIDTH-1:0];
          end
        end
        OP_ALPHA: begin
          alpha  <= alpha_new;
          mark   <= txm;
          acked  <= '0;
          marked <= '0;
        end
        default: ;
      endcase
    end
  end

  // Request capture and working registers
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      case (ctl.op)
        OP_LOAD: begin
          func    <= s_axis_tuser;
          segs    <= s_axis_tdata[15:0];
          ece     <= s_axis_tdata[16];
          txm     <= s_axis_tdata[48:17];
          ackn    <= s_axis_tdata[80:49];
          cwnd    <= s_axis_tdata[112:81];
          infl    <= s_axis_tdata[144:113];
          updated <= 1'b0;
        end
        OP_MUL_BYTES, OP_MUL_DECAY, OP_MUL_REDUCE: begin
          prod <= {{MB{1'b0}}, mul_a} * {{32{1'b0}}, mul_b};
        end
        OP_MUL_GAIN: begin
          acc  <= prod[AW2-1:0];
          prod <= {{MB{1'b0}}, mul_a} * {{32{1'b0}}, mul_b};
        end
        OP_DIV_INIT: begin
          r   <= marked;
          cnt <= '0;
          q   <= ((acked != '0) && (marked >= acked)) ? ONE : '0;
        end
        OP_DIV_STEP: begin
          r   <= ge ? rdiff[COUNT_WIDTH-1:0] : rs[COUNT_WIDTH-1:0];
          q   <= {q[ONE_W-2:0], ge};
          cnt <= cnt + CNT_W'(1);
        end
        OP_ALPHA: begin
          updated <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire && (ctl.op == OP_EMIT)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && (ctl.op == OP_EMIT)) begin
      out_alpha <= alpha;
      if (func) begin
        out_upd <= 1'b0;
        out_red <= reduced;
        out_sst <= (reduced > half) ? reduced : half;
      end else begin
        out_upd <= updated;
        out_red <= '0;
        out_sst <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // A request keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("input ready right after a request was accepted");

  // Alpha never goes above one
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    alpha <= ONE)
    else $error("alpha above one");

  // A window end clears both byte counters
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (ctl.fire && (ctl.op == OP_ALPHA)) |=> (acked == '0) && (marked == '0))
    else $error("byte counters not cleared at window end");

  // Divider remainder stays below the divisor while iterating
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_DIV_STEP) |-> (r < acked))
    else $error("divider remainder not below acked bytes");
`endif

endmodule

FILE: dv/dctcp_alpha_estimator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCTCP alpha estimator testbench
// Drives ack and query requests through the stream ports and rewrites the
// segment size and gain registers between phases. A scoreboard keeps its own
// alpha, byte counters and window mark, predicts every result and compares it
// field by field. Directed corner requests run first, then random traffic
// built from well-formed ack sequences with some queries and noise.
// ----------------------------------------------------------------------------
module dctcp_alpha_estimator_top_test;

  localparam int FRAC   = dctcp_pkg::FRAC_BITS_DEF;
  localparam int ONE    = 1 << FRAC;
  localparam int OUT_DW = ((FRAC + 1 + 64 + 7) / 8) * 8;
  localparam int IN_DW  = dctcp_pkg::IN_DW;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 135;

  localparam logic FUNC_ACK   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct {
    logic [FRAC:0] alpha_now;
    logic          alpha_updated;
    logic [31:0]   reduced_window;
    logic [31:0]   ss_thresh;
  } alpha_result_t;

  // Scoreboard: mirrors the estimator state and holds results still due
  class alpha_scoreboard;
    logic [15:0]   seg_size;
    logic [FRAC:0] gain;
    logic [FRAC:0] alpha;
    logic [31:0]   acked;
    logic [31:0]   marked;
    logic [31:0]   window_mark;
    alpha_result_t awaiting[$];
    int            errors;

    function new();
      seg_size    = dctcp_pkg::SEG_SIZE_RST;
      gain        = dctcp_pkg::GAIN_RST;
      alpha       = (FRAC+1)'(ONE);
      acked       = '0;
      marked      = '0;
      window_mark = '0;
      errors      = 0;
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    function void write_reg(logic [dctcp_pkg::CFG_IW-1:0] idx,
                            logic [dctcp_pkg::CFG_DW-1:0] data);
      if (idx == dctcp_pkg::REG_SEG_SIZE) begin
        seg_size = data[15:0];
      end else if (idx == dctcp_pkg::REG_GAIN) begin
        gain = data[FRAC:0];
      end
    endfunction

    // Saturate at the counter width
    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void note_request(logic func, logic [IN_DW-1:0] d);
      logic [15:0]   segs;
      logic          ece;
      logic [31:0]   tx_mark;
      logic [31:0]   ack_seq;
      logic [63:0]   cwnd;
      logic [31:0]   infl;
      logic [31:0]   bytes;
      logic [31:0]   seq_gap;
      logic [63:0]   g;
      logic [63:0]   frac;
      logic [63:0]   rem;
      logic [63:0]   den;
      logic [63:0]   mix;
      logic [63:0]   reduced;
      alpha_result_t res;
      segs    = d[15:0];
      ece     = d[16];
      tx_mark = d[48:17];
      ack_seq = d[80:49];
      cwnd    = {32'd0, d[112:81]};
      infl    = d[144:113];
      res.alpha_updated  = 1'b0;
      res.reduced_window = '0;
      res.ss_thresh      = '0;
      if (func == FUNC_ACK) begin
        bytes  = {16'd0, segs} * {16'd0, seg_size};
        acked  = sat_add(acked, bytes);
        if (ece) marked = sat_add(marked, bytes);
        seq_gap = ack_seq - window_mark;
        // Close the window once the ack reaches the mark
        if (!seq_gap[31]) begin
          g    = (gain > ONE) ? 64'(ONE) : {{(63-FRAC){1'b0}}, gain};
          den  = {32'd0, acked};
          rem  = {32'd0, marked};
          frac = '0;
          if (acked == 0) begin
            frac = '0;
          end else if (marked >= acked) begin
            frac = 64'(ONE);
          end else begin
            for (int i = 0; i < FRAC; i++) begin
              rem  = rem << 1;
              frac = frac << 1;
              if (rem >= den) begin
                rem     = rem - den;
                frac[0] = 1'b1;
              end
            end
          end
          mix = (((64'(ONE) - g) * {{(63-FRAC){1'b0}}, alpha}) + g * frac) >> FRAC;
          if (mix > 64'(ONE)) mix = 64'(ONE);
          alpha       = mix[FRAC:0];
          window_mark = tx_mark;
          acked       = '0;
          marked      = '0;
          res.alpha_updated = 1'b1;
        end
      end else begin
        reduced = (cwnd * (64'(2 * ONE) - {{(63-FRAC){1'b0}}, alpha})) >> (FRAC + 1);
        res.reduced_window = reduced[31:0];
        res.ss_thresh = (reduced[31:0] > (infl >> 1)) ? reduced[31:0] : (infl >> 1);
      end
      res.alpha_now = alpha;
      awaiting.push_back(res);
    endfunction

    function void check_result(logic [OUT_DW-1:0] d, logic upd);
      alpha_result_t want;
      if (awaiting.size() == 0) begin
        $error("result with none pending: alpha_now=%0d", d[FRAC:0]);
        errors++;
        return;
      end
      want = awaiting.pop_front();
      if (d[FRAC:0] !== want.alpha_now) begin
        $error("alpha_now expected %0d got %0d", want.alpha_now, d[FRAC:0]);
        errors++;
      end
      if (upd !== want.alpha_updated) begin
        $error("alpha_updated expected %0d got %0d", want.alpha_updated, upd);
        errors++;
      end
      if (d[FRAC+32:FRAC+1] !== want.reduced_window) begin
        $error("reduced_window expected %0d got %0d", want.reduced_window,
               d[FRAC+32:FRAC+1]);
        errors++;
      end
      if (d[FRAC+64:FRAC+33] !== want.ss_thresh) begin
        $error("slow_start_thresh expected %0d got %0d", want.ss_thresh,
               d[FRAC+64:FRAC+33]);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dctcp_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [dctcp_pkg::CFG_DW-1:0] cfg_data = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [IN_DW-1:0]             s_axis_tdata = '0;
  logic                         s_axis_tuser = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]            m_axis_tdata;
  logic                         m_axis_tuser;

  alpha_scoreboard sb = new();
  logic            quiet = 1'b0;
  int              cycle_count = 0;
  int              stall_left = 0;

  // Sequence tracking for well-formed ack streams
  logic [31:0]     ack_pos;
  logic [31:0]     snd_nxt;
  int              ece_rate;

  dctcp_alpha_estimator_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Track handshakes on all three channels
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[dctcp_alpha_estimator_top] ERROR");
      $finish;
    end
  end

  // Result side: drop ready in random bursts unless quiet
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Send one request; valid stays high afterwards unless a gap follows
  task automatic issue_request(input logic func, input logic [15:0] segs,
                               input logic ece, input logic [31:0] tx_mark,
                               input logic [31:0] ack_seq, input logic [31:0] cwnd,
                               input logic [31:0] infl);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tdata  <= {7'd0, infl, cwnd, ack_seq, tx_mark, ece, segs};
    s_axis_tuser  <= func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and hold until every pending result has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic set_registers(input logic [dctcp_pkg::CFG_DW-1:0] seg,
                               input logic [dctcp_pkg::CFG_DW-1:0] gain);
    cfg_index <= dctcp_pkg::REG_SEG_SIZE;
    cfg_data  <= seg;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= dctcp_pkg::REG_GAIN;
    cfg_data  <= gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random request: mostly in-order acks, some queries and noise
  task automatic random_request();
    int          pick;
    int          seg_pick;
    logic [15:0] segs;
    pick     = $urandom_range(0, 99);
    seg_pick = $urandom_range(0, 99);
    if (seg_pick < 5) segs = 16'hFFFF;
    else if (seg_pick < 10) segs = 16'($urandom_range(0, 65535));
    else segs = 16'($urandom_range(0, 8));
    if (pick < 20) begin
      issue_request(FUNC_QUERY, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 88) begin
      ack_pos = ack_pos + $urandom_range(0, 1500);
      snd_nxt = ack_pos + $urandom_range(0, 6000);
      issue_request(FUNC_ACK, segs, ($urandom_range(0, 99) < ece_rate), snd_nxt,
                    ack_pos, $urandom, $urandom);
    end else begin
      issue_request(FUNC_ACK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [dctcp_pkg::CFG_DW-1:0] seg_cfg;
    logic [dctcp_pkg::CFG_DW-1:0] gain_cfg;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults: empty window, wrap of the serial test, query extremes
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'd0, 32'd0);
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(FUNC_ACK, 0, 0, 32'd1000, 32'd0, 0, 0);
    issue_request(FUNC_ACK, 10, 1, 32'd2000, 32'd500, 0, 0);
    issue_request(FUNC_ACK, 10, 0, 32'd2000, 32'd1000, 0, 0);
    issue_request(FUNC_ACK, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'd2000 + 32'h8000_0000, 0, 0);
    issue_request(FUNC_ACK, 0, 0, 32'hFFFF_FFFF, 32'd2000 + 32'h7FFF_FFFF, 0, 0);
    issue_request(FUNC_ACK, 3, 1, 32'h10, 32'd5, 0, 0);
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'h1234_5678, 32'hFFFF_FFFE);
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'd1, 32'd3);
    drain();

    // Largest segment and full gain: both counters saturate
    set_registers(17'd65535, 17'(ONE));
    issue_request(FUNC_ACK, 16'hFFFF, 1, 32'h100, 32'd0, 0, 0);
    issue_request(FUNC_ACK, 16'hFFFF, 0, 32'h100, 32'd0, 0, 0);
    issue_request(FUNC_ACK, 16'hFFFF, 1, 32'h100, 32'd0, 0, 0);
    issue_request(FUNC_ACK, 1, 1, 32'h200, 32'h100, 0, 0);
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'd0);
    drain();

    // Zero segment size with a gain above one
    set_registers(17'd0, 17'h1FFFF);
    issue_request(FUNC_ACK, 16'hFFFF, 1, 32'h300, 32'h200, 0, 0);
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Gain of zero freezes alpha
    set_registers(17'd1, 17'd0);
    issue_request(FUNC_ACK, 1, 1, 32'h400, 32'h300, 0, 0);
    issue_request(FUNC_QUERY, 0, 0, 0, 0, 32'h8000_0001, 32'd7);
    drain();

    // Random phases, each under its own register setting
    ack_pos = $urandom;
    snd_nxt = ack_pos;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          seg_cfg  = 17'd1448;
          gain_cfg = 17'd4096;
        end
        1: begin
          seg_cfg  = 17'd1;
          gain_cfg = 17'(ONE);
        end
        2: begin
          seg_cfg  = 17'd65535;
          gain_cfg = 17'($urandom_range(0, 131071));
        end
        3: begin
          seg_cfg  = 17'($urandom_range(0, 131071));
          gain_cfg = 17'($urandom_range(1, 65535));
        end
        4: begin
          seg_cfg  = 17'd0;
          gain_cfg = 17'd4096;
        end
        default: begin
          seg_cfg  = 17'($urandom_range(1, 9000));
          gain_cfg = 17'($urandom_range(0, 16384));
          quiet    = 1'b1;
        end
      endcase
      set_registers(seg_cfg, gain_cfg);
      ece_rate = $urandom_range(0, 100);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In phase 2, hold the sender once mid-phase until the result side is empty
        if (phase == 2 && n == PHASE_ITEMS / 2) drain();
        if (n % 40 == 39) ece_rate = $urandom_range(0, 100);
        random_request();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[dctcp_alpha_estimator_top] OK");
    end else begin
      $display("[dctcp_alpha_estimator_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dctcp_pkg.sv
design/dctcp_useq.sv
design/dctcp_alpha_estimator_top.sv
dv/dctcp_alpha_estimator_top_test.sv
